// File: design/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg: shared types and constants of the grid DDA column raycaster
// Widths, register indexes, reset values, sequencer states and the request
// and response of the shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
package gdr_pkg;

	localparam int MAP_SIZE_DEF      = 32;
	localparam int SCREEN_WIDTH_DEF  = 640;
	localparam int SCREEN_HEIGHT_DEF = 480;

	localparam int COL_W      = 10;
	localparam int LINE_W     = 32;
	localparam int IDX_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;
	localparam int POS_W      = 21;
	localparam int VEC_W      = 18;
	localparam int RED_W      = 8;
	localparam int FRAC_W     = 16;

	localparam int CAM_W  = 25;
	localparam int RAY_W  = 26;
	localparam int PROD_W = 2 * RAY_W;
	localparam int RAD_W  = 50;
	localparam int LEN_W  = 25;
	localparam int DLT_W  = 41;
	localparam int SD_W   = 48;
	localparam int UW     = 64;

	localparam int DIV_N  = 42;
	localparam int SQRT_N = RAD_W / 2;
	localparam int MUL_N  = 17;
	localparam int CNT_W  = 6;

	localparam int ONE_Q16 = 65536;

	localparam logic [POS_W-1:0]        POS_X_RST   = 21'd1441792;
	localparam logic [POS_W-1:0]        POS_Y_RST   = 21'd786432;
	localparam logic signed [VEC_W-1:0] DIR_X_RST   = -18'sd65536;
	localparam logic signed [VEC_W-1:0] DIR_Y_RST   = 18'sd0;
	localparam logic signed [VEC_W-1:0] PLANE_X_RST = 18'sd0;
	localparam logic signed [VEC_W-1:0] PLANE_Y_RST = 18'sd43254;

	localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CAST = 1'b1;

	localparam logic [RED_W-1:0] SIDE0_SHADE = 8'd196;
	localparam logic [RED_W-1:0] RED_MAX     = 8'd255;
	localparam logic [DLT_W-1:0] DELTA_SAT   = 41'h100_0000_0000;

	typedef enum logic [1:0] {
		OP_DIV,
		OP_SQRT,
		OP_MUL
	} iter_op_t;

	typedef struct packed {
		logic           start;
		iter_op_t       op;
		logic [UW-1:0]  a;
		logic [UW-1:0]  b;
	} iter_req_t;

	typedef struct packed {
		logic           done;
		logic [UW-1:0]  result;
	} iter_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CAM,
		S_RX,
		S_RY,
		S_SQX,
		S_SQY,
		S_LEN,
		S_DX,
		S_DY,
		S_SDX,
		S_SDY,
		S_WSTEP,
		S_WTEST,
		S_PERP,
		S_LINE,
		S_SHADE,
		S_OUT
	} state_t;

	function automatic logic [DLT_W-1:0] sat_delta(input logic [UW-1:0] q);
		sat_delta = (q > UW'(DELTA_SAT)) ? DELTA_SAT : q[DLT_W-1:0];
	endfunction

endpackage

// File: design/grid_dda_column_raycaster.sv
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster: column raycaster over a square wall-bit map
// Load requests write one map line; cast requests build a column's ray, walk
// the map with DDA and return the wall stripe, side, hit cell and shade.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  cfg      | cfg_we              | cfg_index, cfg_data
//  in       | in_valid / in_ready | cmd, line_index, line_bits, column
//  out      | out_valid/out_ready | column_echo .. escaped
//
//  A load writes one map line and leaves in_ready high. A cast runs its setup
//  and finish in the shared divide/root/multiply unit and walks the map one
//  cell per step/test state pair (the registered map RAM read sets the step).
//  in_ready drops for the whole cast; a result waits in the output register
//  while the next request is taken. Reset sets control and configuration only.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster
	import gdr_pkg::*;
#(
	parameter int MAP_SIZE      = MAP_SIZE_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [CFG_IDX_W-1:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]            cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic [IDX_W-1:0]                 line_index,
	input  logic [LINE_W-1:0]                line_bits,
	input  logic [COL_W-1:0]                 column,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [COL_W-1:0]                 column_echo,
	output logic [$clog2(SCREEN_HEIGHT)-1:0] draw_start,
	output logic [$clog2(SCREEN_HEIGHT)-1:0] draw_end,
	output logic                             wall_side,
	output logic [RED_W-1:0]                 red_level,
	output logic [$clog2(MAP_SIZE)-1:0]      cell_x,
	output logic [$clog2(MAP_SIZE)-1:0]      cell_y,
	output logic                             escaped
);

	localparam int AW     = $clog2(MAP_SIZE);
	localparam int MC_W   = AW + 2;
	localparam int NUM_W  = MC_W + 19;
	localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
	localparam int HALF_H = SCREEN_HEIGHT / 2;
	localparam int LOW_H  = SCREEN_HEIGHT - HALF_H;

	state_t state_q, state_d;

	logic [POS_W-1:0]        pos_x_q, pos_y_q;
	logic signed [VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	logic [COL_W-1:0]        col_q;
	logic signed [CAM_W-1:0] cam_q;
	logic signed [RAY_W-1:0] rx_q, ry_q;
	logic [RAD_W-1:0]        rad_q;
	logic [LEN_W-1:0]        len_q;
	logic [DLT_W-1:0]        dx_q, dy_q, perp_q, line_q;
	logic [SD_W-1:0]         sdx_q, sdy_q;
	logic signed [MC_W-1:0]  mx_q, my_q;
	logic                    side_q;
	logic                    outside_q;
	logic [RED_W-1:0]        red_q;
	logic                    issued_q;

	logic                    out_valid_q;
	logic [COL_W-1:0]        column_echo_q;
	logic [ROW_W-1:0]        draw_start_q, draw_end_q;
	logic                    wall_side_q;
	logic [RED_W-1:0]        red_level_q;
	logic [AW-1:0]           cell_x_q, cell_y_q;
	logic                    escaped_q;

	iter_req_t req;
	iter_rsp_t rsp;

	logic                     in_fire, cast_start, map_we;
	logic [AW-1:0]            map_raddr;
	logic [LINE_W-1:0]        map_rdata;
	logic                     rx_neg, ry_neg;
	logic [RAY_W-1:0]         abs_rx, abs_ry;
	logic [MUL_N-1:0]         frac_x, frac_y;
	logic signed [RAY_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     step_x;
	logic signed [MC_W-1:0]   mx_next, my_next;
	logic                     outside, hit;
	logic signed [MC_W-1:0]   hit_cell;
	logic signed [NUM_W-1:0]  num;
	logic [NUM_W-1:0]         abs_num;
	logic [DLT_W-2:0]         half;
	logic [ROW_W-1:0]         ds, de;
	logic [AW-1:0]            cx, cy;
	logic                     out_load;
	logic                     unit_state;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= POS_X_RST;
			pos_y_q   <= POS_Y_RST;
			dir_x_q   <= DIR_X_RST;
			dir_y_q   <= DIR_Y_RST;
			plane_x_q <= PLANE_X_RST;
			plane_y_q <= PLANE_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data;
				REG_POS_Y:   pos_y_q   <= cfg_data;
				REG_DIR_X:   dir_x_q   <= cfg_data[VEC_W-1:0];
				REG_DIR_Y:   dir_y_q   <= cfg_data[VEC_W-1:0];
				REG_PLANE_X: plane_x_q <= cfg_data[VEC_W-1:0];
				REG_PLANE_Y: plane_y_q <= cfg_data[VEC_W-1:0];
				default: begin
					pos_x_q <= pos_x_q;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign cast_start = in_fire && (cmd == CMD_CAST);
	assign map_we     = in_fire && (cmd == CMD_LOAD) && (int'(line_index) < MAP_SIZE);

	gdr_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAP_SIZE)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (AW'(line_index)),
		.wdata (line_bits),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	gdr_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign rx_neg = rx_q[RAY_W-1];
	assign ry_neg = ry_q[RAY_W-1];
	assign abs_rx = rx_neg ? RAY_W'(-rx_q) : RAY_W'(rx_q);
	assign abs_ry = ry_neg ? RAY_W'(-ry_q) : RAY_W'(ry_q);
	assign frac_x = rx_neg ? MUL_N'(pos_x_q[FRAC_W-1:0])
		: MUL_N'(ONE_Q16) - MUL_N'(pos_x_q[FRAC_W-1:0]);
	assign frac_y = ry_neg ? MUL_N'(pos_y_q[FRAC_W-1:0])
		: MUL_N'(ONE_Q16) - MUL_N'(pos_y_q[FRAC_W-1:0]);

	// walk
	assign step_x    = sdx_q < sdy_q;
	assign mx_next   = rx_neg ? mx_q - MC_W'(1) : mx_q + MC_W'(1);
	assign my_next   = ry_neg ? my_q - MC_W'(1) : my_q + MC_W'(1);
	assign map_raddr = step_x ? AW'(mx_next) : AW'(mx_q);
	assign outside   = (mx_q < 0) || (int'(mx_q) >= MAP_SIZE)
		|| (my_q < 0) || (int'(my_q) >= MAP_SIZE);
	assign hit       = outside || ((int'(my_q) < LINE_W) && map_rdata[my_q[4:0]]);

	// perpendicular distance numerator
	assign hit_cell = side_q ? my_q : mx_q;
	assign num = (NUM_W'(hit_cell) <<< FRAC_W)
		- NUM_W'(side_q ? pos_y_q : pos_x_q)
		+ (((side_q ? ry_neg : rx_neg)) ? NUM_W'(ONE_Q16) : NUM_W'(0));
	assign abs_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	// shared multiplier for ray and squares
	always_comb begin
		case (state_q)
			S_RX: begin
				mul_a = RAY_W'(plane_x_q);
				mul_b = RAY_W'(cam_q);
			end
			S_RY: begin
				mul_a = RAY_W'(plane_y_q);
				mul_b = RAY_W'(cam_q);
			end
			S_SQY: begin
				mul_a = ry_q;
				mul_b = ry_q;
			end
			default: begin
				mul_a = rx_q;
				mul_b = rx_q;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// stripe and cell
	assign half = line_q[DLT_W-1:1];
	assign ds = (half >= (DLT_W-1)'(HALF_H)) ? '0 : ROW_W'((DLT_W-1)'(HALF_H) - half);
	assign de = (half >= (DLT_W-1)'(LOW_H)) ? ROW_W'(SCREEN_HEIGHT - 1)
		: ROW_W'(half + (DLT_W-1)'(HALF_H));
	assign cx = (mx_q < 0) ? '0 : (int'(mx_q) >= MAP_SIZE) ? AW'(MAP_SIZE - 1) : AW'(mx_q);
	assign cy = (my_q < 0) ? '0 : (int'(my_q) >= MAP_SIZE) ? AW'(MAP_SIZE - 1) : AW'(my_q);

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign unit_state = (state_q == S_CAM) || (state_q == S_LEN) || (state_q == S_DX)
		|| (state_q == S_DY) || (state_q == S_SDX) || (state_q == S_SDY)
		|| (state_q == S_PERP) || (state_q == S_LINE) || (state_q == S_SHADE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (cast_start) state_d = S_CAM;
			S_CAM:   if (rsp.done) state_d = S_RX;
			S_RX:    state_d = S_RY;
			S_RY:    state_d = S_SQX;
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_LEN;
			S_LEN:   if (rsp.done) state_d = S_DX;
			S_DX:    if (rsp.done) state_d = S_DY;
			S_DY:    if (rsp.done) state_d = S_SDX;
			S_SDX:   if (rsp.done) state_d = S_SDY;
			S_SDY:   if (rsp.done) state_d = S_WSTEP;
			S_WSTEP: state_d = S_WTEST;
			S_WTEST: state_d = hit ? S_PERP : S_WSTEP;
			S_PERP:  if (rsp.done) state_d = S_LINE;
			S_LINE:  if (rsp.done) state_d = side_q ? S_SHADE : S_OUT;
			S_SHADE: if (rsp.done) state_d = S_OUT;
			S_OUT:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// unit requests
	always_comb begin
		req.start = unit_state && !issued_q;
		req.op    = OP_DIV;
		req.a     = '0;
		req.b     = '0;
		case (state_q)
			S_CAM: begin
				req.a = UW'({col_q, 17'b0});
				req.b = UW'(SCREEN_WIDTH);
			end
			S_LEN: begin
				req.op = OP_SQRT;
				req.a  = UW'(rad_q);
			end
			S_DX: begin
				req.a = UW'({len_q, 16'b0});
				req.b = UW'(abs_rx);
			end
			S_DY: begin
				req.a = UW'({len_q, 16'b0});
				req.b = UW'(abs_ry);
			end
			S_SDX: begin
				req.op = OP_MUL;
				req.a  = UW'(dx_q);
				req.b  = UW'(frac_x);
			end
			S_SDY: begin
				req.op = OP_MUL;
				req.a  = UW'(dy_q);
				req.b  = UW'(frac_y);
			end
			S_PERP: begin
				req.a = UW'({abs_num, 16'b0});
				req.b = UW'(side_q ? abs_ry : abs_rx);
			end
			S_LINE: begin
				req.a = UW'(SCREEN_HEIGHT) << FRAC_W;
				req.b = UW'(perp_q);
			end
			S_SHADE: begin
				req.a = UW'(RED_MAX) << FRAC_W;
				req.b = UW'(sdy_q);
			end
			default: begin
				req.op = OP_DIV;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp.done) begin
				issued_q <= 1'b0;
			end else if (req.start) begin
				issued_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cast_start) begin
			col_q <= column;
			mx_q  <= MC_W'(pos_x_q[POS_W-1:FRAC_W]);
			my_q  <= MC_W'(pos_y_q[POS_W-1:FRAC_W]);
		end
		case (state_q)
			S_CAM: if (rsp.done) cam_q <= rsp.result[CAM_W-1:0] - CAM_W'(ONE_Q16);
			S_RX:  rx_q <= RAY_W'(dir_x_q) + RAY_W'(prod >>> FRAC_W);
			S_RY:  ry_q <= RAY_W'(dir_y_q) + RAY_W'(prod >>> FRAC_W);
			S_SQX: rad_q <= RAD_W'(prod);
			S_SQY: rad_q <= rad_q + RAD_W'(prod);
			S_LEN: if (rsp.done) len_q <= rsp.result[LEN_W-1:0];
			S_DX:  if (rsp.done) dx_q <= sat_delta(rsp.result);
			S_DY:  if (rsp.done) dy_q <= sat_delta(rsp.result);
			S_SDX: if (rsp.done) sdx_q <= SD_W'(rsp.result >> FRAC_W);
			S_SDY: if (rsp.done) sdy_q <= SD_W'(rsp.result >> FRAC_W);
			S_WSTEP: begin
				if (step_x) begin
					sdx_q  <= sdx_q + SD_W'(dx_q);
					mx_q   <= mx_next;
					side_q <= 1'b0;
				end else begin
					sdy_q  <= sdy_q + SD_W'(dy_q);
					my_q   <= my_next;
					side_q <= 1'b1;
				end
			end
			S_WTEST: outside_q <= outside;
			S_PERP:  if (rsp.done) perp_q <= sat_delta(rsp.result);
			S_LINE: begin
				if (rsp.done) begin
					line_q <= sat_delta(rsp.result);
					red_q  <= SIDE0_SHADE;
				end
			end
			S_SHADE: begin
				if (rsp.done) begin
					red_q <= (rsp.result > UW'(RED_MAX)) ? RED_MAX : rsp.result[RED_W-1:0];
				end
			end
			default: begin
				outside_q <= outside_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			column_echo_q <= col_q;
			draw_start_q  <= ds;
			draw_end_q    <= de;
			wall_side_q   <= side_q;
			red_level_q   <= red_q;
			cell_x_q      <= cx;
			cell_y_q      <= cy;
			escaped_q     <= outside_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign column_echo = column_echo_q;
	assign draw_start  = draw_start_q;
	assign draw_end    = draw_end_q;
	assign wall_side   = wall_side_q;
	assign red_level   = red_level_q;
	assign cell_x      = cell_x_q;
	assign cell_y      = cell_y_q;
	assign escaped     = escaped_q;

endmodule

// File: design/gdr_ram.sv
// ----------------------------------------------------------------------------
// gdr_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gdr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/gdr_iter.sv
// ----------------------------------------------------------------------------
// gdr_iter: shared iterative arithmetic unit
// One adder/subtractor reused bit by bit for restoring division, digit by
// digit square root and shift-add multiplication.
// ----------------------------------------------------------------------------
module gdr_iter
	import gdr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  iter_req_t req,
	output iter_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	iter_op_t         op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [UW-1:0]    r_q;
	logic [UW-1:0]    x_q;
	logic [UW-1:0]    y_q;

	logic [UW-1:0] a_sel;
	logic [UW-1:0] b_sel;
	logic          add;
	logic [UW:0]   sum;
	logic          ge;

	always_comb begin
		a_sel = r_q;
		b_sel = x_q;
		add   = 1'b0;
		case (op_q)
			OP_DIV: begin
				a_sel = {r_q[UW-2:0], x_q[DIV_N-1]};
				b_sel = y_q;
			end
			OP_SQRT: begin
				a_sel = {r_q[UW-3:0], x_q[RAD_W-1 -: 2]};
				b_sel = {y_q[UW-3:0], 2'b01};
			end
			OP_MUL: begin
				a_sel = r_q;
				b_sel = y_q[0] ? x_q : '0;
				add   = 1'b1;
			end
			default: begin
				add = 1'b0;
			end
		endcase
		sum = {1'b0, a_sel} + {1'b0, (add ? b_sel : ~b_sel)} + (UW+1)'(!add);
	end

	assign ge = sum[UW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					OP_DIV:  cnt_q <= CNT_W'(DIV_N);
					OP_SQRT: cnt_q <= CNT_W'(SQRT_N);
					OP_MUL:  cnt_q <= CNT_W'(MUL_N);
					default: cnt_q <= CNT_W'(DIV_N);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			x_q <= req.a;
			y_q <= (req.op == OP_SQRT) ? '0 : req.b;
		end else if (busy_q) begin
			case (op_q)
				OP_DIV: begin
					r_q <= ge ? sum[UW-1:0] : a_sel;
					x_q <= {x_q[UW-2:0], ge};
				end
				OP_SQRT: begin
					r_q <= ge ? sum[UW-1:0] : a_sel;
					y_q <= {y_q[UW-2:0], ge};
					x_q <= {x_q[UW-3:0], 2'b00};
				end
				OP_MUL: begin
					r_q <= sum[UW-1:0];
					x_q <= {x_q[UW-2:0], 1'b0};
					y_q <= {1'b0, y_q[UW-1:1]};
				end
				default: begin
					r_q <= r_q;
				end
			endcase
		end
	end

	always_comb begin
		rsp.done = done_q;
		case (op_q)
			OP_DIV:  rsp.result = UW'(x_q[DIV_N-1:0]);
			OP_SQRT: rsp.result = y_q;
			OP_MUL:  rsp.result = r_q;
			default: rsp.result = r_q;
		endcase
	end

endmodule

// File: design/gdr_chk.sv
// ----------------------------------------------------------------------------
// gdr_chk: port checker for the grid DDA column raycaster
// Watches the request and result channels and the result payload.
// ----------------------------------------------------------------------------
module gdr_chk
	import gdr_pkg::*;
#(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             cmd,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [$clog2(SCREEN_HEIGHT)-1:0] draw_start,
	input logic [$clog2(SCREEN_HEIGHT)-1:0] draw_end,
	input logic                             wall_side,
	input logic [RED_W-1:0]                 red_level
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(draw_start) && $stable(red_level))
		else $error("result dropped or changed while stalled");

	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_CAST) |=> !in_ready)
		else $error("request taken during a cast");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_LOAD) |=> in_ready)
		else $error("load request left the block busy");

	a_stripe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (draw_start <= draw_end) && (wall_side || red_level == SIDE0_SHADE))
		else $error("bad stripe or shade");

endmodule

bind grid_dda_column_raycaster gdr_chk #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_gdr_chk (.*);
